>>> sv/sldr_pkg.sv
// ----------------------------------------------------------------------------
// sldr_pkg
// shared types and constants of the rrip set dueling replacement engine
// ----------------------------------------------------------------------------
package sldr_pkg;

  localparam int NumSetsDef       = 2048;
  localparam int NumWaysDef       = 16;
  localparam int LeaderSpacingDef = 64;
  localparam int LeaderGroupsDef  = 32;
  localparam int SelectorWidthDef = 10;

  localparam int SetInW   = 11;
  localparam int AddrW    = 20;
  localparam int StrideW  = 21;
  localparam int StreakW  = 4;
  localparam int UpdW     = 8;
  localparam int SigW     = 6;
  localparam int SigDepth = 64;
  localparam int PcW      = 13;
  localparam int CfgW     = 4;
  localparam int LipOffset = 32;
  localparam int DecayMax = 8;

  localparam logic [1:0] RrpvTop = 2'd3;
  localparam logic [1:0] RrpvMru = 2'd0;
  localparam logic [1:0] CntMax  = 2'd3;
  localparam logic [StreakW-1:0] StreakMax = 4'd15;

  localparam logic KindVictim = 1'b0;
  localparam logic KindUpdate = 1'b1;

  typedef enum logic {
    CFG_STREAM_LENGTH = 1'b0,
    CFG_DECAY_SHIFT   = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_TRAIN
  } state_t;

  typedef struct packed {
    logic [AddrW-1:0]   last_addr;
    logic [StrideW-1:0] last_stride;
    logic [StreakW-1:0] streak;
    logic               reuse_flag;
    logic [UpdW-1:0]    upd_count;
  } stride_rec_t;

  localparam int RecW = $bits(stride_rec_t);

endpackage

>>> sv/sldr_ram.sv
// ----------------------------------------------------------------------------
// sldr_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module sldr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sldr_stride.sv
// ----------------------------------------------------------------------------
// sldr_stride
// per set stride detector: streak tracking and streaming decision
// ----------------------------------------------------------------------------
module sldr_stride (
  input  sldr_pkg::stride_rec_t           rec,
  input  logic [sldr_pkg::AddrW-1:0]      addr,
  input  logic [sldr_pkg::CfgW-1:0]       stream_length,
  output sldr_pkg::stride_rec_t           rec_next,
  output logic                            streaming
);

  logic [sldr_pkg::StrideW-1:0] d;
  logic                         same;

  always_comb begin
    d = {1'b0, addr} - {1'b0, rec.last_addr};
    same = (rec.streak != '0) && (d == rec.last_stride) && (d != '0);
    rec_next = rec;
    rec_next.last_addr = addr;
    streaming = 1'b0;
    if (same) begin
      if (rec.streak < sldr_pkg::StreakMax) begin
        rec_next.streak = rec.streak + 1'b1;
      end
      streaming = (rec_next.streak >= stream_length);
    end else begin
      rec_next.last_stride = d;
      rec_next.streak = sldr_pkg::StreakW'(1);
    end
  end

endmodule

>>> sv/ship_lip_dueling_cache_replacement.sv
// ----------------------------------------------------------------------------
// ship_lip_dueling_cache_replacement
// 2-bit rrip replacement engine with ship / lip set dueling and stream bypass
// ----------------------------------------------------------------------------
// a victim request reads the per set rows, then ages and writes them back. an
// update reads the rows, then modifies and writes them back while the
// signature counter of the line is read, then trains that counter unless it
// bypasses or its way is invalid. busy stays high until the item is finished,
// and done pulses for one cycle with the result; the receiver cannot stall it.
// after reset the block sweeps all NUM_SETS rows to their reset values (busy
// high) before the first item is taken. config writes are always accepted.
module ship_lip_dueling_cache_replacement #(
  parameter int NUM_SETS       = sldr_pkg::NumSetsDef,
  parameter int NUM_WAYS       = sldr_pkg::NumWaysDef,
  parameter int LEADER_SPACING = sldr_pkg::LeaderSpacingDef,
  parameter int LEADER_GROUPS  = sldr_pkg::LeaderGroupsDef,
  parameter int SELECTOR_WIDTH = sldr_pkg::SelectorWidthDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [sldr_pkg::SetInW-1:0]   set_index,
  input  logic [3:0]                    way,
  input  logic [sldr_pkg::AddrW-1:0]    paddr,
  input  logic [sldr_pkg::PcW-1:0]      pc,
  input  logic                          hit,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [sldr_pkg::CfgW-1:0]     cfg_data,
  output logic                          done,
  output logic [3:0]                    victim_way,
  output logic                          bypassed
);

  localparam int SetW   = $clog2(NUM_SETS);
  localparam int SpW    = $clog2(LEADER_SPACING);
  localparam int RowW   = 2 * NUM_WAYS;
  localparam int SRowW  = sldr_pkg::SigW * NUM_WAYS;
  localparam int CntAW  = $clog2(sldr_pkg::SigDepth);
  localparam logic [SELECTOR_WIDTH-1:0] SelMax = '1;
  localparam logic [SELECTOR_WIDTH-1:0] SelMid = SelMax >> 1;

  sldr_pkg::state_t state, state_next;

  logic [SetW-1:0]              sweep;
  logic [sldr_pkg::CfgW-1:0]    stream_length;
  logic [sldr_pkg::CfgW-1:0]    decay_shift;
  logic [SELECTOR_WIDTH-1:0]    sel;

  logic                         kind_q;
  logic [SetW-1:0]              set_q;
  logic [3:0]                   way_q;
  logic [sldr_pkg::AddrW-1:0]   addr_q;
  logic                         hit_q;
  logic [sldr_pkg::SigW-1:0]    sig_q;
  logic                         ship_lead_q;
  logic                         lip_lead_q;
  logic [sldr_pkg::SigW-1:0]    old_q;

  logic [RowW-1:0]              rrpv_rd, rrpv_wd;
  logic [SRowW-1:0]             sig_rd, sig_wd;
  logic [sldr_pkg::RecW-1:0]    rec_rd, rec_wd;
  logic [1:0]                   cnt_rd, cnt_wd;
  logic                         row_we, cnt_we;
  logic [SetW-1:0]              row_waddr, row_raddr;
  logic [CntAW-1:0]             cnt_waddr, cnt_raddr;

  sldr_pkg::stride_rec_t        rec_cur, rec_trk, rec_new;
  logic                         streaming;

  logic                         accept;
  logic                         way_ok;
  logic                         ship_lead, lip_lead;
  logic [1:0]                   ins;
  logic                         do_bypass;
  logic [sldr_pkg::SigW-1:0]    old_sig;
  logic [RowW-1:0]              aged;
  logic [3:0]                   vic;
  logic [31:0]                  s32, grp, off;
  logic [sldr_pkg::UpdW-1:0]    upd_mask;
  logic [3:0]                   ds_eff;
  logic                         any3, any2, any1, found;
  logic [1:0]                   top, add, f;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign rec_cur   = sldr_pkg::stride_rec_t'(rec_rd);

  sldr_ram #(.WIDTH(RowW), .DEPTH(NUM_SETS)) u_rrpv (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(rrpv_wd),
    .raddr(row_raddr), .rdata(rrpv_rd)
  );

  sldr_ram #(.WIDTH(SRowW), .DEPTH(NUM_SETS)) u_sig (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(sig_wd),
    .raddr(row_raddr), .rdata(sig_rd)
  );

  sldr_ram #(.WIDTH(sldr_pkg::RecW), .DEPTH(NUM_SETS)) u_rec (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(rec_wd),
    .raddr(row_raddr), .rdata(rec_rd)
  );

  sldr_ram #(.WIDTH(2), .DEPTH(sldr_pkg::SigDepth)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wd),
    .raddr(cnt_raddr), .rdata(cnt_rd)
  );

  sldr_stride u_stride (
    .rec(rec_cur), .addr(addr_q), .stream_length(stream_length),
    .rec_next(rec_trk), .streaming(streaming)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sldr_pkg::ST_CLEAR: begin
        if (sweep == SetW'(NUM_SETS - 1)) state_next = sldr_pkg::ST_IDLE;
      end
      sldr_pkg::ST_IDLE: begin
        if (accept) state_next = sldr_pkg::ST_LOOKUP;
      end
      sldr_pkg::ST_LOOKUP: begin
        if (kind_q == sldr_pkg::KindUpdate && way_ok && !do_bypass) begin
          state_next = sldr_pkg::ST_TRAIN;
        end else begin
          state_next = sldr_pkg::ST_IDLE;
        end
      end
      sldr_pkg::ST_TRAIN: state_next = sldr_pkg::ST_IDLE;
      default: state_next = sldr_pkg::ST_IDLE;
    endcase
  end

  // victim search, insertion and row updates
  always_comb begin
    way_ok = ({2'b00, way_q} < 6'(NUM_WAYS));
    s32 = 32'(set_q);
    grp = s32 >> SpW;
    off = s32 & 32'(LEADER_SPACING - 1);
    ship_lead = (grp < 32'(LEADER_GROUPS)) && (off == 32'd0);
    lip_lead  = (grp < 32'(LEADER_GROUPS)) && (off == 32'(sldr_pkg::LipOffset));

    any3 = 1'b0; any2 = 1'b0; any1 = 1'b0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      f = rrpv_rd[2*i +: 2];
      if (f == 2'd3) any3 = 1'b1;
      if (f == 2'd2) any2 = 1'b1;
      if (f == 2'd1) any1 = 1'b1;
    end
    top = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
    add = sldr_pkg::RrpvTop - top;
    found = 1'b0;
    vic = '0;
    aged = rrpv_rd;
    for (int i = 0; i < NUM_WAYS; i++) begin
      aged[2*i +: 2] = rrpv_rd[2*i +: 2] + add;
      if (!found && aged[2*i +: 2] == sldr_pkg::RrpvTop) begin
        found = 1'b1;
        vic = 4'(i);
      end
    end

    old_sig = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (4'(i) == way_q) old_sig = sig_rd[sldr_pkg::SigW*i +: sldr_pkg::SigW];
    end

    if (ship_lead) ins = (cnt_rd == sldr_pkg::CntMax) ? 2'd0 : sldr_pkg::RrpvTop;
    else if (lip_lead) ins = sldr_pkg::RrpvTop;
    else if (sel >= SelMid) ins = (cnt_rd == sldr_pkg::CntMax) ? 2'd0 : sldr_pkg::RrpvTop;
    else ins = sldr_pkg::RrpvTop;
    do_bypass = !hit_q && streaming && (cnt_rd == 2'd0) && !rec_cur.reuse_flag;

    ds_eff = (decay_shift > 4'(sldr_pkg::DecayMax)) ? 4'(sldr_pkg::DecayMax) : decay_shift;
    upd_mask = sldr_pkg::UpdW'((9'd1 << ds_eff) - 9'd1);
    rec_new = rec_trk;
    if (!do_bypass) begin
      if (hit_q) rec_new.reuse_flag = 1'b1;
      rec_new.upd_count = rec_trk.upd_count + 1'b1;
      if ((rec_new.upd_count & upd_mask) == '0) rec_new.reuse_flag = 1'b0;
    end

    row_we = 1'b0;
    row_waddr = set_q;
    rrpv_wd = rrpv_rd;
    sig_wd = sig_rd;
    rec_wd = rec_new;
    row_raddr = SetW'(set_index);
    cnt_we = 1'b0;
    cnt_waddr = old_q;
    cnt_wd = cnt_rd;
    cnt_raddr = pc[7:2] ^ pc[12:7];

    unique case (state)
      sldr_pkg::ST_CLEAR: begin
        row_we = 1'b1;
        row_waddr = sweep;
        rrpv_wd = '1;
        sig_wd = '0;
        rec_wd = '0;
        cnt_we = (32'(sweep) < sldr_pkg::SigDepth);
        cnt_waddr = CntAW'(sweep);
        cnt_wd = '0;
      end
      sldr_pkg::ST_IDLE: ;
      sldr_pkg::ST_LOOKUP: begin
        cnt_raddr = old_sig;
        if (kind_q == sldr_pkg::KindVictim) begin
          row_we = 1'b1;
          rrpv_wd = aged;
          rec_wd = rec_rd;
        end else if (way_ok) begin
          row_we = 1'b1;
          for (int i = 0; i < NUM_WAYS; i++) begin
            if (4'(i) == way_q) begin
              rrpv_wd[2*i +: 2] = hit_q ? sldr_pkg::RrpvMru :
                                  do_bypass ? sldr_pkg::RrpvTop : ins;
              if (!hit_q) sig_wd[sldr_pkg::SigW*i +: sldr_pkg::SigW] = sig_q;
            end
          end
        end
      end
      sldr_pkg::ST_TRAIN: begin
        cnt_we = 1'b1;
        if (hit_q) cnt_wd = (cnt_rd == sldr_pkg::CntMax) ? cnt_rd : cnt_rd + 2'd1;
        else cnt_wd = (cnt_rd == 2'd0) ? cnt_rd : cnt_rd - 2'd1;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state != sldr_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sldr_pkg::ST_CLEAR;
      sweep <= '0;
      stream_length <= 4'd4;
      decay_shift <= 4'd4;
      sel <= SelMid;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (state == sldr_pkg::ST_CLEAR) sweep <= sweep + 1'b1;
      if (cfg_valid && cfg_ready) begin
        unique case (sldr_pkg::cfg_index_t'(cfg_index))
          sldr_pkg::CFG_STREAM_LENGTH: stream_length <= cfg_data;
          sldr_pkg::CFG_DECAY_SHIFT:   decay_shift <= cfg_data;
          default: ;
        endcase
      end
      if (state == sldr_pkg::ST_LOOKUP && state_next == sldr_pkg::ST_IDLE) begin
        done <= 1'b1;
      end
      if (state == sldr_pkg::ST_TRAIN) begin
        done <= 1'b1;
        if (ship_lead_q) begin
          if (hit_q && sel != SelMax) sel <= sel + 1'b1;
          else if (!hit_q && sel != '0) sel <= sel - 1'b1;
        end else if (lip_lead_q) begin
          if (hit_q && sel != '0) sel <= sel - 1'b1;
          else if (!hit_q && sel != SelMax) sel <= sel + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind;
      set_q <= SetW'(set_index);
      way_q <= way;
      addr_q <= paddr;
      hit_q <= hit;
      sig_q <= pc[7:2] ^ pc[12:7];
    end
    if (state == sldr_pkg::ST_LOOKUP) begin
      ship_lead_q <= ship_lead;
      lip_lead_q <= lip_lead;
      old_q <= old_sig;
      victim_way <= (kind_q == sldr_pkg::KindVictim) ? vic : 4'd0;
      bypassed <= (kind_q == sldr_pkg::KindUpdate) && way_ok && do_bypass;
    end
  end

endmodule
